// ===== hdl/rdsp_pkg.sv =====
// Package for the radial distance to shower plane block.
// Holds register indexes, status codes and the control group shared by the pipeline modules.
// No dependencies.
`default_nettype none
package rdsp_pkg;
	localparam int DEPTH_BITS = 40;
	localparam int CFG_INDEX_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_Z = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SMAX_X = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SMAX_Y = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SMAX_Z = 3'd6;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_ZERO = 2'd1;
	localparam status_t STATUS_SAT = 2'd2;

	typedef struct packed {
		logic valid;
		logic zero;
		logic sat;
	} ctrl_t;
endpackage
`default_nettype wire

// ===== hdl/rdsp_if.sv =====
// Channel interfaces of the radial distance block: hit requests, results and register writes.
// Depends on rdsp_pkg.
`default_nettype none
interface rdsp_hit_if #(
	parameter int POSITION_WIDTH = 18,
	parameter int NORMAL_FRACTION_BITS = 14
);
	logic valid;
	logic ready;
	logic signed [POSITION_WIDTH-1:0] hit_x;
	logic signed [POSITION_WIDTH-1:0] hit_y;
	logic signed [POSITION_WIDTH-1:0] hit_z;
	logic signed [NORMAL_FRACTION_BITS+1:0] axis_x;
	logic signed [NORMAL_FRACTION_BITS+1:0] axis_y;
	logic signed [NORMAL_FRACTION_BITS+1:0] axis_z;
	modport source(output valid, hit_x, hit_y, hit_z, axis_x, axis_y, axis_z, input ready);
	modport sink(input valid, hit_x, hit_y, hit_z, axis_x, axis_y, axis_z, output ready);
endinterface

interface rdsp_res_if import rdsp_pkg::*; #(
	parameter int POSITION_WIDTH = 18
);
	logic valid;
	logic ready;
	logic [POSITION_WIDTH-1:0] radial_distance;
	status_t status;
	modport source(output valid, radial_distance, status, input ready);
	modport sink(input valid, radial_distance, status, output ready);
endinterface

interface rdsp_cfg_if import rdsp_pkg::*; #(
	parameter int DATA_WIDTH = 18
);
	logic valid;
	logic ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [DATA_WIDTH-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/rdsp_front.sv =====
// Front end: the plane normal products and the numerator and denominator of the depth, in two stages.
// Depends on rdsp_pkg.
`default_nettype none
module rdsp_front import rdsp_pkg::*; #(
	parameter int POSITION_WIDTH = 18,
	parameter int NORMAL_FRACTION_BITS = 14
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic signed [POSITION_WIDTH-1:0] pos [3],
	input  wire logic signed [NORMAL_FRACTION_BITS+1:0] axis [3],
	input  wire logic signed [NORMAL_FRACTION_BITS+1:0] normal [3],
	input  wire logic signed [POSITION_WIDTH-1:0] offset,
	output logic out_valid,
	output logic zero,
	output logic neg,
	output logic [POSITION_WIDTH+NORMAL_FRACTION_BITS+1:0] nmag,
	output logic [2*NORMAL_FRACTION_BITS+3:0] dmag,
	output logic signed [POSITION_WIDTH-1:0] pos_out [3],
	output logic signed [NORMAL_FRACTION_BITS+1:0] axis_out [3]
);
	localparam int P = POSITION_WIDTH;
	localparam int F = NORMAL_FRACTION_BITS;
	localparam int NAW = 2*F + 4;
	localparam int NPPW = P + F + 2;
	localparam int NPW = 2*F + 5;
	localparam int NUMW = P + F + 3;

	logic valid_s1;
	logic signed [NAW-1:0] prod_na_s1 [3];
	logic signed [NPPW-1:0] prod_np_s1 [3];
	logic signed [P-1:0] offset_s1;
	logic signed [P-1:0] pos_s1 [3];
	logic signed [F+1:0] axis_s1 [3];
	logic signed [NPW-1:0] np_c;
	logic signed [NUMW-1:0] num_c;
	logic signed [NPW-1:0] np_neg_c;
	logic signed [NUMW-1:0] num_neg_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_na_s1[k] <= normal[k] * axis[k];
				prod_np_s1[k] <= normal[k] * pos[k];
				pos_s1[k] <= pos[k];
				axis_s1[k] <= axis[k];
			end
			offset_s1 <= offset;
		end
	end

	always_comb begin
		np_c = NPW'(prod_na_s1[0]) + NPW'(prod_na_s1[1]) + NPW'(prod_na_s1[2]);
		num_c = (NUMW'(offset_s1) <<< F) - NUMW'(prod_np_s1[0]) - NUMW'(prod_np_s1[1])
			- NUMW'(prod_np_s1[2]);
		np_neg_c = -np_c;
		num_neg_c = -num_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero <= (np_c == '0);
			neg <= num_c[NUMW-1] ^ np_c[NPW-1];
			nmag <= num_c[NUMW-1] ? num_neg_c[NUMW-2:0] : num_c[NUMW-2:0];
			dmag <= np_c[NPW-1] ? np_neg_c[NPW-2:0] : np_c[NPW-2:0];
			for (int k = 0; k < 3; k++) begin
				pos_out[k] <= pos_s1[k];
				axis_out[k] <= axis_s1[k];
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rdsp_div.sv =====
// Restoring divider with one quotient bit per pipeline stage; the divisor and a tag travel along.
// Depends on rdsp_pkg.
`default_nettype none
module rdsp_div import rdsp_pkg::*; #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 32,
	parameter int SHIFT = 15,
	parameter int TAG_W = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [TAG_W-1:0] tag,
	output logic out_valid,
	output logic [NUM_W+SHIFT-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);
	localparam int QW = NUM_W + SHIFT;

	logic valid_s [1:QW];
	logic [DEN_W-1:0] rem_s [1:QW];
	logic [DEN_W-1:0] den_s [1:QW];
	logic [QW-1:0] dvd_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];
	logic [TAG_W-1:0] tag_s [1:QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic v_in;
		logic [DEN_W-1:0] r_in;
		logic [DEN_W-1:0] d_in;
		logic [QW-1:0] n_in;
		logic [QW-1:0] q_in;
		logic [TAG_W-1:0] t_in;
		logic [DEN_W:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign d_in = den;
			assign n_in = {num, {SHIFT{1'b0}}};
			assign q_in = '0;
			assign t_in = tag;
		end else begin : g_next
			assign v_in = valid_s[i];
			assign r_in = rem_s[i];
			assign d_in = den_s[i];
			assign n_in = dvd_s[i];
			assign q_in = quo_s[i];
			assign t_in = tag_s[i];
		end

		assign trial = {r_in, n_in[QW-1]};
		assign ge = (trial >= {1'b0, d_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
				den_s[i+1] <= d_in;
				dvd_s[i+1] <= {n_in[QW-2:0], 1'b0};
				quo_s[i+1] <= {q_in[QW-2:0], ge};
				tag_s[i+1] <= t_in;
			end
		end
	end

	assign out_valid = valid_s[QW];
	assign quo = quo_s[QW];
	assign tag_out = tag_s[QW];
endmodule
`default_nettype wire

// ===== hdl/rdsp_proj.sv =====
// Projection: depth rounding and overflow, shifts along the axis, offset vector and its squared length.
// Depends on rdsp_pkg.
`default_nettype none
module rdsp_proj import rdsp_pkg::*; #(
	parameter int POSITION_WIDTH = 18,
	parameter int NORMAL_FRACTION_BITS = 14,
	parameter int QUO_W = 49
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [QUO_W-1:0] quo,
	input  wire logic zero,
	input  wire logic neg,
	input  wire logic signed [POSITION_WIDTH-1:0] pos [3],
	input  wire logic signed [NORMAL_FRACTION_BITS+1:0] axis [3],
	input  wire logic signed [POSITION_WIDTH-1:0] smax [3],
	output logic [2*POSITION_WIDTH+1:0] sum,
	output ctrl_t ctrl
);
	localparam int P = POSITION_WIDTH;
	localparam int F = NORMAL_FRACTION_BITS;
	localparam int QXW = (QUO_W > DEPTH_BITS + 1) ? QUO_W : DEPTH_BITS + 2;
	localparam int AW = F + 2;
	localparam int MW = DEPTH_BITS + AW;
	localparam int RSW = MW + 1 - F;
	localparam int VW = DEPTH_BITS + 5;

	ctrl_t c_s1, c_s2, c_s3, c_s4;
	logic neg_s1;
	logic [DEPTH_BITS-1:0] tmag_s1;
	logic signed [P-1:0] pos_s1 [3];
	logic signed [F+1:0] axis_s1 [3];
	logic [MW-1:0] m_s2 [3];
	logic sgn_s2 [3];
	logic signed [P-1:0] pos_s2 [3];
	logic [P-1:0] absv_s3 [3];
	logic [2*P-1:0] sq_s4 [3];

	logic [QXW-1:0] qx;
	logic [DEPTH_BITS+1:0] qr;
	logic sat_div;
	logic [AW-1:0] amag [3];
	logic [MW:0] rnd [3];
	logic [RSW-1:0] mr [3];
	logic signed [VW-1:0] sh [3];
	logic signed [VW-1:0] v [3];
	logic [VW-1:0] absv [3];
	logic [2:0] over;

	always_comb begin
		qx = QXW'(quo);
		qr = (DEPTH_BITS+2)'(qx[DEPTH_BITS:0]) + (DEPTH_BITS+2)'(1);
		sat_div = ((qx >> (DEPTH_BITS + 1)) != '0) || (qx[DEPTH_BITS:0] == '1);
		for (int k = 0; k < 3; k++) begin
			amag[k] = axis_s1[k][AW-1] ? AW'(-axis_s1[k]) : AW'(axis_s1[k]);
			rnd[k] = (MW+1)'(m_s2[k]) + ((MW+1)'(1) << (F - 1));
			mr[k] = RSW'(rnd[k] >> F);
			sh[k] = sgn_s2[k] ? -$signed(VW'(mr[k])) : $signed(VW'(mr[k]));
			v[k] = VW'(pos_s2[k]) + sh[k] - VW'(smax[k]);
			absv[k] = v[k][VW-1] ? VW'(-v[k]) : VW'(v[k]);
			over[k] = (absv[k] >> P) != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
			c_s4 <= '0;
			ctrl <= '0;
		end else if (en) begin
			c_s1 <= '{valid: in_valid, zero: zero, sat: sat_div};
			c_s2 <= c_s1;
			c_s3 <= '{valid: c_s2.valid, zero: c_s2.zero, sat: c_s2.sat || (over != '0)};
			c_s4 <= c_s3;
			ctrl <= c_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			tmag_s1 <= qr[DEPTH_BITS:1];
			for (int k = 0; k < 3; k++) begin
				pos_s1[k] <= pos[k];
				axis_s1[k] <= axis[k];
				m_s2[k] <= tmag_s1 * amag[k];
				sgn_s2[k] <= neg_s1 ^ axis_s1[k][AW-1];
				pos_s2[k] <= pos_s1[k];
				absv_s3[k] <= absv[k][P-1:0];
				sq_s4[k] <= absv_s3[k] * absv_s3[k];
			end
			sum <= (2*P+2)'(sq_s4[0]) + (2*P+2)'(sq_s4[1]) + (2*P+2)'(sq_s4[2]);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/rdsp_sqrt.sv =====
// Pipelined square root, one root bit per stage, with rounding, status and the output register.
// Depends on rdsp_pkg.
`default_nettype none
module rdsp_sqrt import rdsp_pkg::*; #(
	parameter int POSITION_WIDTH = 18
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic [2*POSITION_WIDTH+1:0] sum,
	input  wire ctrl_t ctrl,
	output logic out_valid,
	output logic [POSITION_WIDTH-1:0] radial_distance,
	output status_t status
);
	localparam int P = POSITION_WIDTH;
	localparam int SW = 2*P + 2;
	localparam int RW = P + 1;
	localparam int RMW = P + 4;

	ctrl_t c_s [1:RW];
	logic [RMW-1:0] rem_s [1:RW];
	logic [RW-1:0] root_s [1:RW];
	logic [SW-1:0] rad_s [1:RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		ctrl_t c_in;
		logic [RMW-1:0] r_in;
		logic [RW-1:0] q_in;
		logic [SW-1:0] s_in;
		logic [RMW-1:0] cur;
		logic [RMW-1:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign c_in = ctrl;
			assign r_in = '0;
			assign q_in = '0;
			assign s_in = sum;
		end else begin : g_next
			assign c_in = c_s[i];
			assign r_in = rem_s[i];
			assign q_in = root_s[i];
			assign s_in = rad_s[i];
		end

		assign cur = {r_in[RMW-3:0], s_in[SW-1:SW-2]};
		assign trial = RMW'({q_in, 2'b01});
		assign ge = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_s[i+1] <= '0;
			end else if (en) begin
				c_s[i+1] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? cur - trial : cur;
				root_s[i+1] <= {q_in[RW-2:0], ge};
				rad_s[i+1] <= {s_in[SW-3:0], 2'b00};
			end
		end
	end

	logic [RW:0] rounded;
	logic over;

	always_comb begin
		rounded = (RW+1)'(root_s[RW])
			+ (RW+1)'(rem_s[RW] > RMW'(root_s[RW]));
		over = (rounded >> P) != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= c_s[RW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (c_s[RW].zero) begin
				radial_distance <= '0;
				status <= STATUS_ZERO;
			end else if (c_s[RW].sat || over) begin
				radial_distance <= '1;
				status <= STATUS_SAT;
			end else begin
				radial_distance <= rounded[P-1:0];
				status <= STATUS_OK;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/radial_distance_to_shower_plane.sv =====
// Top level of the radial distance to shower plane block: configuration registers and pipeline.
// Depends on rdsp_pkg, rdsp_if, rdsp_front, rdsp_div, rdsp_proj and rdsp_sqrt.
//
// The block takes one hit per clock while the output does not stall and returns one result per
// hit, in order. The divider resolves one quotient bit per stage and the square root one root
// bit per stage. The whole pipeline holds while a result waits on the output, so hit.ready is
// high only while res.valid is low or res.ready is high. Register writes are always taken and
// are meant to be made only while no hit is in flight.
`default_nettype none
module radial_distance_to_shower_plane import rdsp_pkg::*; #(
	parameter int POSITION_WIDTH = 18,
	parameter int NORMAL_FRACTION_BITS = 14
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rdsp_cfg_if.sink cfg,
	rdsp_hit_if.sink hit,
	rdsp_res_if.source res
);
	localparam int P = POSITION_WIDTH;
	localparam int F = NORMAL_FRACTION_BITS;
	localparam int NMW = P + F + 2;
	localparam int DMW = 2*F + 4;
	localparam int QW = NMW + F + 1;
	localparam int TAG_W = 3*P + 3*(F + 2) + 2;

	logic signed [F+1:0] normal_q [3];
	logic signed [P-1:0] offset_q;
	logic signed [P-1:0] smax_q [3];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= (F+2)'(1) << F;
			offset_q <= '0;
			smax_q[0] <= '0;
			smax_q[1] <= '0;
			smax_q[2] <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NORMAL_X: normal_q[0] <= cfg.data[F+1:0];
				REG_NORMAL_Y: normal_q[1] <= cfg.data[F+1:0];
				REG_NORMAL_Z: normal_q[2] <= cfg.data[F+1:0];
				REG_OFFSET: offset_q <= cfg.data[P-1:0];
				REG_SMAX_X: smax_q[0] <= cfg.data[P-1:0];
				REG_SMAX_Y: smax_q[1] <= cfg.data[P-1:0];
				REG_SMAX_Z: smax_q[2] <= cfg.data[P-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !res.valid || res.ready;
	assign hit.ready = en;

	logic signed [P-1:0] pos [3];
	logic signed [F+1:0] axis [3];
	assign pos[0] = hit.hit_x;
	assign pos[1] = hit.hit_y;
	assign pos[2] = hit.hit_z;
	assign axis[0] = hit.axis_x;
	assign axis[1] = hit.axis_y;
	assign axis[2] = hit.axis_z;

	logic fr_valid, fr_zero, fr_neg;
	logic [NMW-1:0] fr_nmag;
	logic [DMW-1:0] fr_dmag;
	logic signed [P-1:0] fr_pos [3];
	logic signed [F+1:0] fr_axis [3];

	rdsp_front #(.POSITION_WIDTH(P), .NORMAL_FRACTION_BITS(F)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(hit.valid),
		.pos(pos), .axis(axis), .normal(normal_q), .offset(offset_q),
		.out_valid(fr_valid), .zero(fr_zero), .neg(fr_neg),
		.nmag(fr_nmag), .dmag(fr_dmag), .pos_out(fr_pos), .axis_out(fr_axis)
	);

	logic [TAG_W-1:0] tag_in, tag_out;
	logic dv_valid;
	logic [QW-1:0] dv_quo;
	assign tag_in = {fr_pos[0], fr_pos[1], fr_pos[2], fr_axis[0], fr_axis[1], fr_axis[2],
		fr_zero, fr_neg};

	rdsp_div #(.NUM_W(NMW), .DEN_W(DMW), .SHIFT(F + 1), .TAG_W(TAG_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.num(fr_nmag), .den(fr_dmag), .tag(tag_in),
		.out_valid(dv_valid), .quo(dv_quo), .tag_out(tag_out)
	);

	logic signed [P-1:0] dv_pos [3];
	logic signed [F+1:0] dv_axis [3];
	logic dv_zero, dv_neg;
	assign {dv_pos[0], dv_pos[1], dv_pos[2], dv_axis[0], dv_axis[1], dv_axis[2],
		dv_zero, dv_neg} = tag_out;

	logic [2*P+1:0] pj_sum;
	ctrl_t pj_ctrl;

	rdsp_proj #(.POSITION_WIDTH(P), .NORMAL_FRACTION_BITS(F), .QUO_W(QW)) u_proj (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(dv_valid),
		.quo(dv_quo), .zero(dv_zero), .neg(dv_neg), .pos(dv_pos), .axis(dv_axis),
		.smax(smax_q), .sum(pj_sum), .ctrl(pj_ctrl)
	);

	rdsp_sqrt #(.POSITION_WIDTH(P)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .sum(pj_sum), .ctrl(pj_ctrl),
		.out_valid(res.valid), .radial_distance(res.radial_distance), .status(res.status)
	);

`ifndef SYNTHESIS
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == STATUS_ZERO |-> res.radial_distance == '0)
		else $error("zero normal product with nonzero distance");
	a_sat_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == STATUS_SAT |-> res.radial_distance == '1)
		else $error("saturated result is not all ones");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status == STATUS_OK || res.status == STATUS_ZERO
		|| res.status == STATUS_SAT))
		else $error("undefined status code");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.radial_distance))
		else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_radial_distance_to_shower_plane.sv =====
// Testbench for the radial distance to shower plane block: drives hits and register writes,
// predicts each distance in integer arithmetic and checks results in order.
// Depends on rdsp_pkg, rdsp_if and radial_distance_to_shower_plane.
`timescale 1ns / 1ps
`default_nettype none
module tb_radial_distance_to_shower_plane;
	import rdsp_pkg::*;

	localparam int PW = 18;
	localparam int FB = 14;
	localparam int NW = FB + 2;
	localparam longint RMAX = (64'd1 << PW) - 1;
	localparam int LATENCY = 76;
	localparam longint LIMIT = 2000000;

	typedef struct packed {
		logic [PW-1:0] radial_distance;
		status_t status;
	} result_t;

	class distance_board;
		result_t pending[$];
		int errors;

		function void note_hit(result_t r);
			pending.push_back(r);
		endfunction

		function void check_result(logic [PW-1:0] got_distance, status_t st);
			result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result radial_distance=%0d status=%0d", got_distance, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got_distance !== e.radial_distance) begin
				$error("radial_distance expected %0d actual %0d", e.radial_distance,
					got_distance);
				errors++;
			end
			if (st !== e.status) begin
				$error("status expected %0d actual %0d", e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #4 clk = ~clk;

	rdsp_cfg_if #(.DATA_WIDTH(PW)) cfg();
	rdsp_hit_if #(.POSITION_WIDTH(PW), .NORMAL_FRACTION_BITS(FB)) hit();
	rdsp_res_if #(.POSITION_WIDTH(PW)) res();

	radial_distance_to_shower_plane #(.POSITION_WIDTH(PW), .NORMAL_FRACTION_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .hit(hit), .res(res)
	);

	distance_board board = new();
	longint pn[3], psm[3], poff;
	int send_idle, recv_idle;
	longint cycles;
	bit timed_out;

	function automatic longint sx(longint v, int w);
		longint m;
		m = v & ((64'd1 << w) - 1);
		if (m[w-1]) m = m - (64'd1 << w);
		return m;
	endfunction

	function automatic longint rsqrt(longint unsigned x);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd4294967296;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= x) lo = mid; else hi = mid;
		end
		if (x - lo * lo > lo) lo++;
		return lo;
	endfunction

	function automatic result_t predict_distance(longint p[3], longint a[3]);
		result_t r;
		longint np, num, q, rem, tmag, dep, sh, m;
		longint v[3];
		longint unsigned nm, dm, sum, sq;
		bit neg;
		np = 0;
		num = poff * (64'd1 << FB);
		for (int k = 0; k < 3; k++) begin
			np += pn[k] * a[k];
			num -= pn[k] * p[k];
		end
		if (np == 0) begin
			r.radial_distance = '0;
			r.status = STATUS_ZERO;
			return r;
		end
		r.radial_distance = '1;
		r.status = STATUS_SAT;
		nm = num < 0 ? -num : num;
		dm = np < 0 ? -np : np;
		neg = (num < 0) != (np < 0);
		q = nm / dm;
		rem = nm % dm;
		if (q >= (64'd1 << (DEPTH_BITS - FB))) return r;
		tmag = (((q << FB) + ((rem << FB) / dm)) * 2 + ((((rem << FB) % dm) * 2) >= dm) + 1)
			>> 1;
		if (tmag >= (64'd1 << DEPTH_BITS)) return r;
		dep = neg ? -tmag : tmag;
		for (int k = 0; k < 3; k++) begin
			m = (tmag * (a[k] < 0 ? -a[k] : a[k]) + (64'd1 << (FB - 1))) >> FB;
			sh = ((dep < 0) != (a[k] < 0)) ? -m : m;
			v[k] = p[k] + sh - psm[k];
			if ((v[k] < 0 ? -v[k] : v[k]) > RMAX) return r;
		end
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			sq = v[k] * v[k];
			sum += sq;
		end
		q = rsqrt(sum);
		if (q > RMAX) return r;
		r.radial_distance = q[PW-1:0];
		r.status = STATUS_OK;
		return r;
	endfunction

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, longint val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val[PW-1:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		@(posedge clk);
		case (idx)
			REG_NORMAL_X: pn[0] = sx(val, NW);
			REG_NORMAL_Y: pn[1] = sx(val, NW);
			REG_NORMAL_Z: pn[2] = sx(val, NW);
			REG_OFFSET: poff = sx(val, PW);
			REG_SMAX_X: psm[0] = sx(val, PW);
			REG_SMAX_Y: psm[1] = sx(val, PW);
			default: psm[2] = sx(val, PW);
		endcase
	endtask

	task automatic set_plane(longint nx, longint ny, longint nz, longint d,
		longint sx0, longint sy0, longint sz0);
		write_reg(REG_NORMAL_X, nx);
		write_reg(REG_NORMAL_Y, ny);
		write_reg(REG_NORMAL_Z, nz);
		write_reg(REG_OFFSET, d);
		write_reg(REG_SMAX_X, sx0);
		write_reg(REG_SMAX_Y, sy0);
		write_reg(REG_SMAX_Z, sz0);
	endtask

	task automatic send_hit(longint px, longint py, longint pz, longint ax, longint ay,
		longint az);
		longint p[3], a[3];
		while ($urandom_range(99) < send_idle) begin
			hit.valid <= 0;
			@(posedge clk);
		end
		hit.valid <= 1;
		hit.hit_x <= px[PW-1:0];
		hit.hit_y <= py[PW-1:0];
		hit.hit_z <= pz[PW-1:0];
		hit.axis_x <= ax[NW-1:0];
		hit.axis_y <= ay[NW-1:0];
		hit.axis_z <= az[NW-1:0];
		p = '{sx(px, PW), sx(py, PW), sx(pz, PW)};
		a = '{sx(ax, NW), sx(ay, NW), sx(az, NW)};
		@(posedge clk);
		while (!hit.ready) @(posedge clk);
		board.note_hit(predict_distance(p, a));
	endtask

	task automatic drain();
		hit.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic longint rnd_pos();
		case ($urandom_range(3))
			0: return longint'($urandom_range(262143)) - 131072;
			1: return longint'($urandom_range(4000)) - 2000;
			2: return $urandom_range(1) ? 131071 : -131072;
			default: return longint'($urandom_range(20000)) - 10000;
		endcase
	endfunction

	function automatic longint rnd_norm();
		case ($urandom_range(3))
			0: return longint'($urandom_range(65535)) - 32768;
			1: return longint'($urandom_range(32768)) - 16384;
			2: return $urandom_range(1) ? 16384 : -16384;
			default: return longint'($urandom_range(2000)) - 1000;
		endcase
	endfunction

	task automatic random_hits(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				send_hit(rnd_pos(), rnd_pos(), rnd_pos(), rnd_norm(), rnd_norm(), rnd_norm());
			else
				send_hit(psm[0] + longint'($urandom_range(4000)) - 2000,
					psm[1] + longint'($urandom_range(4000)) - 2000,
					psm[2] + longint'($urandom_range(4000)) - 2000,
					pn[0] + longint'($urandom_range(2000)) - 1000,
					pn[1] + longint'($urandom_range(2000)) - 1000,
					pn[2] + longint'($urandom_range(2000)) - 1000);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 0;
		end else begin
			if (res.valid && res.ready) board.check_result(res.radial_distance, res.status);
			res.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb_radial_distance_to_shower_plane failed");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		timed_out = 0;
		send_idle = 0;
		recv_idle = 0;
		pn = '{0, 0, 16384};
		psm = '{0, 0, 0};
		poff = 0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.data = '0;
		hit.valid = 0;
		{hit.hit_x, hit.hit_y, hit.hit_z} = '0;
		{hit.axis_x, hit.axis_y, hit.axis_z} = '0;
		res.ready = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_hit(100, -200, 300, 0, 0, 16384);
		send_hit(131071, 131071, 131071, 16384, 16384, 16384);
		send_hit(-131072, -131072, -131072, -16384, -16384, -16384);
		send_hit(5, 5, 5, 16384, 0, 0);
		send_hit(0, 0, 100000, 0, 0, 1);
		send_hit(-1, -1, -1, -32768, 32767, -1);
		drain();

		set_plane(-16384, 16384, 32767, 131071, -131072, 131071, -131072);
		send_hit(0, 0, 0, 16384, 0, 0);
		send_hit(0, 0, 0, 1, -1, 0);
		send_hit(131071, -131072, 0, -32768, -32768, -32768);
		send_hit(-5, 7, 9, 32767, 32767, 32767);
		drain();

		set_plane(11585, 0, 11585, 500, 400, 0, 307);
		send_hit(410, 3, 290, 11585, 0, 11585);
		send_hit(0, 0, 0, 0, 16384, 0);
		send_hit(400, 0, 307, 0, 0, 16384);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 21 : ph == 1 ? 80 : 0;
			recv_idle = ph == 0 ? 80 : ph == 1 ? 21 : 0;
			for (int s = 0; s < 3; s++) begin
				set_plane(rnd_norm(), rnd_norm(), rnd_norm(), rnd_pos(), rnd_pos(), rnd_pos(),
					rnd_pos());
				random_hits(115);
				drain();
			end
		end
		drain();
		if (board.errors == 0)
			$display("tb_radial_distance_to_shower_plane passed");
		else
			$display("tb_radial_distance_to_shower_plane failed");
		$finish;
	end
endmodule
`default_nettype wire
